FILE: design/aph_pkg.sv
// ----------------------------------------------------------------------------
// aph_pkg
// Shared types and constants for the ATA PIO host sequencer.
// ----------------------------------------------------------------------------
package aph_pkg;

  localparam int unsigned WordsPerSectorDef = 256;
  localparam int unsigned NumDrivesDef      = 4;
  localparam logic [19:0] PollLimitReset    = 20'd100000;

  localparam logic [2:0] OP_RD   = 3'd0;
  localparam logic [2:0] OP_WR   = 3'd1;
  localparam logic [2:0] OP_ID   = 3'd2;
  localparam logic [2:0] OP_REP  = 3'd3;
  localparam logic [2:0] OP_HWW  = 3'd4;

  localparam logic [2:0] K_BWR  = 3'd0;
  localparam logic [2:0] K_BRD  = 3'd1;
  localparam logic [2:0] K_WORD = 3'd2;
  localparam logic [2:0] K_NEED = 3'd3;
  localparam logic [2:0] K_DONE = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ABSENT  = 3'd1;
  localparam logic [2:0] ST_DEVERR  = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_NODRV   = 3'd4;
  localparam logic [2:0] ST_PACKET  = 3'd5;

  // classified job handed from the front to the back
  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  drive;
    logic [27:0] lba;
    logic [7:0]  cnt;
    logic [15:0] word;
  } aph_job_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        channel;
    logic        use_ctrl_port;
    logic [2:0]  reg_offset;
    logic        wants_reply;
    logic [15:0] data;
    logic [2:0]  status;
    logic [63:0] sector_total;
    logic        last;
  } aph_res_t;

endpackage

FILE: design/aph_front.sv
// ----------------------------------------------------------------------------
// aph_front
// Input stage with a two-entry queue; holds one accepted item per slot.
// ----------------------------------------------------------------------------
module aph_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  aph_pkg::aph_job_t in_job,
  output logic              q_valid,
  input  logic              q_ready,
  output aph_pkg::aph_job_t q_job
);
  import aph_pkg::*;

  aph_job_t  mem_r [2];
  aph_job_t  mem_nxt0, mem_nxt1;
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic      push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_job    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    mem_nxt0 = (push && !wp_r) ? in_job : mem_r[0];
    mem_nxt1 = (push && wp_r) ? in_job : mem_r[1];
  end

  always_ff @(posedge clk) begin
    mem_r[0] <= mem_nxt0;
    mem_r[1] <= mem_nxt1;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule

FILE: design/aph_back.sv
// ----------------------------------------------------------------------------
// aph_back
// Sequencer: expands one job into its result items, one per cycle while res_ready is high.
// ----------------------------------------------------------------------------
module aph_back #(
  parameter int unsigned WORDS_PER_SECTOR = aph_pkg::WordsPerSectorDef,
  parameter int unsigned NUM_DRIVES       = aph_pkg::NumDrivesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [19:0]       poll_limit,
  input  logic              q_valid,
  output logic              q_ready,
  input  aph_pkg::aph_job_t q_job,
  output logic              res_valid,
  input  logic              res_ready,
  output aph_pkg::aph_res_t res
);
  import aph_pkg::*;

  localparam logic [8:0] WPS = 9'(WORDS_PER_SECTOR);

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b00000000001,
    PH_XFER   = 11'b00000000010,
    PH_RDATA  = 11'b00000000100,
    PH_WDATA  = 11'b00000001000,
    PH_FLUSH  = 11'b00000010000,
    PH_IDFST  = 11'b00000100000,
    PH_IDBSY  = 11'b00001000000,
    PH_IDMID  = 11'b00010000000,
    PH_IDHI   = 11'b00100000000,
    PH_IDDRQ  = 11'b01000000000,
    PH_IDDATA = 11'b10000000000
  } phase_t;

  // emission script kinds
  localparam logic [2:0] SC_RW  = 3'd0;
  localparam logic [2:0] SC_ID  = 3'd1;
  localparam logic [2:0] SC_ONE = 3'd2;
  localparam logic [2:0] SC_TWO = 3'd3;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  drv_r, drv_nxt;
  logic        isw_r, isw_nxt;
  logic [8:0]  sec_r, sec_nxt, wl_r, wl_nxt;
  logic [19:0] pc_r, pc_nxt;
  logic [3:0]  pres_r, pres_nxt;
  logic        l48_r, l48_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [7:0]  rbs_r, rbs_nxt;

  // emitter
  logic        busy_r, busy_nxt;
  logic [2:0]  sc_r, sc_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [3:0]  len_r, len_nxt;
  aph_res_t    r0_r, r0_nxt, r1_r, r1_nxt;
  logic [27:0] lba_r, lba_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        opw_r, opw_nxt;

  logic [19:0] lim;
  logic [7:0]  b;
  logic [8:0]  wdec, sdec, idx;
  logic        take;

  assign lim  = (poll_limit == 20'd0) ? 20'd1 : poll_limit;
  assign b    = q_job.word[7:0];
  assign wdec = wl_r - 9'd1;
  assign sdec = sec_r - 9'd1;
  assign idx  = 9'd256 - wl_r;
  // next job may enter while the last result of the current one leaves
  assign q_ready = !busy_r || (res_ready && step_r == len_r);
  assign take = q_valid && q_ready;

  function automatic aph_res_t mk(input logic [2:0] k, input logic ch, input logic c,
                                  input logic [2:0] o, input logic w, input logic [15:0] d,
                                  input logic [2:0] s, input logic [63:0] t);
    aph_res_t x;
    x.kind = k; x.channel = ch; x.use_ctrl_port = c; x.reg_offset = o;
    x.wants_reply = w; x.data = d; x.status = s; x.sector_total = t; x.last = 1'b0;
    return x;
  endfunction

  // current result from script
  always_comb begin
    logic ch;
    ch = drv_r[1];
    res = r0_r;
    unique case (sc_r)
      SC_RW: begin
        unique case (step_r)
          4'd0: res = mk(K_BWR, ch, 1'b0, 3'd6, 1'b0,
                         {8'h00, 8'hE0 | {3'b000, drv_r[0], lba_r[27:24]}}, ST_OK, 64'd0);
          4'd1, 4'd2, 4'd3, 4'd4: res = mk(K_BRD, ch, 1'b1, 3'd0, 1'b0, 16'd0, ST_OK, 64'd0);
          4'd5: res = mk(K_BWR, ch, 1'b0, 3'd2, 1'b0, {8'h00, cnt_r}, ST_OK, 64'd0);
          4'd6: res = mk(K_BWR, ch, 1'b0, 3'd3, 1'b0, {8'h00, lba_r[7:0]}, ST_OK, 64'd0);
          4'd7: res = mk(K_BWR, ch, 1'b0, 3'd4, 1'b0, {8'h00, lba_r[15:8]}, ST_OK, 64'd0);
          4'd8: res = mk(K_BWR, ch, 1'b0, 3'd5, 1'b0, {8'h00, lba_r[23:16]}, ST_OK, 64'd0);
          4'd9: res = mk(K_BWR, ch, 1'b0, 3'd7, 1'b0, opw_r ? 16'h0030 : 16'h0020,
                         ST_OK, 64'd0);
          default: res = mk(K_BRD, ch, 1'b0, 3'd7, 1'b1, 16'd0, ST_OK, 64'd0);
        endcase
      end
      SC_ID: begin
        unique case (step_r)
          4'd0: res = mk(K_BWR, ch, 1'b0, 3'd6, 1'b0, {8'h00, 3'b101, drv_r[0], 4'h0},
                         ST_OK, 64'd0);
          4'd1, 4'd2, 4'd3, 4'd4, 4'd10, 4'd11, 4'd12, 4'd13:
            res = mk(K_BRD, ch, 1'b1, 3'd0, 1'b0, 16'd0, ST_OK, 64'd0);
          4'd5: res = mk(K_BWR, ch, 1'b0, 3'd2, 1'b0, 16'd0, ST_OK, 64'd0);
          4'd6: res = mk(K_BWR, ch, 1'b0, 3'd3, 1'b0, 16'd0, ST_OK, 64'd0);
          4'd7: res = mk(K_BWR, ch, 1'b0, 3'd4, 1'b0, 16'd0, ST_OK, 64'd0);
          4'd8: res = mk(K_BWR, ch, 1'b0, 3'd5, 1'b0, 16'd0, ST_OK, 64'd0);
          4'd9: res = mk(K_BWR, ch, 1'b0, 3'd7, 1'b0, 16'h00EC, ST_OK, 64'd0);
          default: res = mk(K_BRD, ch, 1'b0, 3'd7, 1'b1, 16'd0, ST_OK, 64'd0);
        endcase
      end
      SC_ONE:  res = r0_r;
      default: begin
        // third item of the flush sequence is the first status read
        if (step_r == 4'd0) res = r0_r;
        else if (step_r == 4'd1) res = r1_r;
        else res = mk(K_BRD, ch, 1'b0, 3'd7, 1'b1, 16'd0, ST_OK, 64'd0);
      end
    endcase
    res.last = (step_r == len_r);
  end

  assign res_valid = busy_r;

  always_comb begin
    logic [1:0] dv;
    logic       ch;
    logic       ok, err, pend;
    phase_nxt = phase_r; drv_nxt = drv_r; isw_nxt = isw_r; sec_nxt = sec_r;
    wl_nxt = wl_r; pc_nxt = pc_r; pres_nxt = pres_r; l48_nxt = l48_r;
    acc_nxt = acc_r; rbs_nxt = rbs_r;
    busy_nxt = busy_r; sc_nxt = sc_r; step_nxt = step_r; len_nxt = len_r;
    r0_nxt = r0_r; r1_nxt = r1_r; lba_nxt = lba_r; cnt_nxt = cnt_r; opw_nxt = opw_r;
    dv = q_job.drive;
    ch = drv_r[1];
    ok = 1'b0; err = 1'b0; pend = 1'b0;

    if (busy_r && res_ready) begin
      if (step_r == len_r) busy_nxt = 1'b0;
      else step_nxt = step_r + 4'd1;
    end

    if (take) begin
      step_nxt = 4'd0;
      unique case (1'b1)
        ((q_job.op == OP_RD || q_job.op == OP_WR) && phase_r == PH_IDLE): begin
          drv_nxt = dv;
          if (32'(dv) >= NUM_DRIVES || !pres_r[dv]) begin
            busy_nxt = 1'b1; sc_nxt = SC_ONE; len_nxt = 4'd0;
            r0_nxt = mk(K_DONE, dv[1], 1'b0, 3'd0, 1'b0, 16'd0, ST_ABSENT, 64'd0);
          end else begin
            isw_nxt = q_job.op[0];
            sec_nxt = (q_job.cnt == 8'd0) ? 9'd256 : {1'b0, q_job.cnt};
            lba_nxt = q_job.lba; cnt_nxt = q_job.cnt; opw_nxt = q_job.op[0];
            busy_nxt = 1'b1; sc_nxt = SC_RW; len_nxt = 4'd10;
            pc_nxt = 20'd1; phase_nxt = PH_XFER;
          end
        end
        (q_job.op == OP_ID && phase_r == PH_IDLE): begin
          drv_nxt = dv;
          if (32'(dv) >= NUM_DRIVES) begin
            busy_nxt = 1'b1; sc_nxt = SC_ONE; len_nxt = 4'd0;
            r0_nxt = mk(K_DONE, dv[1], 1'b0, 3'd0, 1'b0, 16'd0, ST_ABSENT, 64'd0);
          end else begin
            pres_nxt[dv] = 1'b0; acc_nxt = 64'd0; l48_nxt = 1'b0;
            busy_nxt = 1'b1; sc_nxt = SC_ID; len_nxt = 4'd14;
            pc_nxt = 20'd1; phase_nxt = PH_IDFST;
          end
        end
        (q_job.op == OP_REP): begin
          sc_nxt = SC_ONE; len_nxt = 4'd0;
          busy_nxt = !phase_r[0] && !phase_r[3];
          // status poll phases
          if (phase_r == PH_XFER || phase_r == PH_FLUSH || phase_r == PH_IDDRQ) begin
            if (!b[7]) begin
              err = b[0] || b[5];
              ok  = !err && (phase_r == PH_FLUSH || b[3]);
            end
            pend = !err && !ok;
            if (err)
              r0_nxt = mk(K_DONE, ch, 1'b0, 3'd0, 1'b0, 16'd0, ST_DEVERR, 64'd0);
            else if (pend && pc_r >= lim)
              r0_nxt = mk(K_DONE, ch, 1'b0, 3'd0, 1'b0, 16'd0, ST_TIMEOUT, 64'd0);
            else if (pend) begin
              pc_nxt = pc_r + 20'd1;
              r0_nxt = mk(K_BRD, ch, 1'b0, 3'd7, 1'b1, 16'd0, ST_OK, 64'd0);
            end else if (phase_r == PH_FLUSH)
              r0_nxt = mk(K_DONE, ch, 1'b0, 3'd0, 1'b0, 16'd0, ST_OK, 64'd0);
            else if (phase_r == PH_IDDRQ) begin
              wl_nxt = 9'd256; phase_nxt = PH_IDDATA;
              r0_nxt = mk(K_BRD, ch, 1'b0, 3'd0, 1'b1, 16'd0, ST_OK, 64'd0);
            end else if (isw_r) begin
              wl_nxt = WPS; phase_nxt = PH_WDATA;
              r0_nxt = mk(K_NEED, ch, 1'b0, 3'd0, 1'b0, 16'd0, ST_OK, 64'd0);
            end else begin
              wl_nxt = WPS; phase_nxt = PH_RDATA;
              r0_nxt = mk(K_BRD, ch, 1'b0, 3'd0, 1'b1, 16'd0, ST_OK, 64'd0);
            end
            if (r0_nxt.kind == K_DONE) phase_nxt = PH_IDLE;
          end else if (phase_r == PH_RDATA) begin
            sc_nxt = SC_TWO; len_nxt = 4'd1;
            r0_nxt = mk(K_WORD, ch, 1'b0, 3'd0, 1'b0, q_job.word, ST_OK, 64'd0);
            wl_nxt = wdec;
            if (wdec != 9'd0)
              r1_nxt = mk(K_BRD, ch, 1'b0, 3'd0, 1'b1, 16'd0, ST_OK, 64'd0);
            else begin
              sec_nxt = sdec;
              if (sdec != 9'd0) begin
                pc_nxt = 20'd1; phase_nxt = PH_XFER;
                r1_nxt = mk(K_BRD, ch, 1'b0, 3'd7, 1'b1, 16'd0, ST_OK, 64'd0);
              end else begin
                phase_nxt = PH_IDLE;
                r1_nxt = mk(K_DONE, ch, 1'b0, 3'd0, 1'b0, 16'd0, ST_OK, 64'd0);
              end
            end
          end else if (phase_r == PH_IDFST) begin
            if (b == 8'd0) begin
              phase_nxt = PH_IDLE;
              r0_nxt = mk(K_DONE, ch, 1'b0, 3'd0, 1'b0, 16'd0, ST_NODRV, 64'd0);
            end else begin
              pc_nxt = 20'd1; phase_nxt = PH_IDBSY;
              r0_nxt = mk(K_BRD, ch, 1'b0, 3'd7, 1'b1, 16'd0, ST_OK, 64'd0);
            end
          end else if (phase_r == PH_IDBSY) begin
            if (b[7]) begin
              if (pc_r >= lim) begin
                phase_nxt = PH_IDLE;
                r0_nxt = mk(K_DONE, ch, 1'b0, 3'd0, 1'b0, 16'd0, ST_TIMEOUT, 64'd0);
              end else begin
                pc_nxt = pc_r + 20'd1;
                r0_nxt = mk(K_BRD, ch, 1'b0, 3'd7, 1'b1, 16'd0, ST_OK, 64'd0);
              end
            end else begin
              phase_nxt = PH_IDMID;
              r0_nxt = mk(K_BRD, ch, 1'b0, 3'd4, 1'b1, 16'd0, ST_OK, 64'd0);
            end
          end else if (phase_r == PH_IDMID) begin
            rbs_nxt = b; phase_nxt = PH_IDHI;
            r0_nxt = mk(K_BRD, ch, 1'b0, 3'd5, 1'b1, 16'd0, ST_OK, 64'd0);
          end else if (phase_r == PH_IDHI) begin
            if (rbs_r != 8'd0 || b != 8'd0) begin
              phase_nxt = PH_IDLE;
              r0_nxt = mk(K_DONE, ch, 1'b0, 3'd0, 1'b0, 16'd0, ST_PACKET, 64'd0);
            end else begin
              pc_nxt = 20'd1; phase_nxt = PH_IDDRQ;
              r0_nxt = mk(K_BRD, ch, 1'b0, 3'd7, 1'b1, 16'd0, ST_OK, 64'd0);
            end
          end else if (phase_r == PH_IDDATA) begin
            if (idx == 9'd60) acc_nxt[15:0] = q_job.word;
            else if (idx == 9'd61) acc_nxt[31:16] = q_job.word;
            else if (idx == 9'd83) l48_nxt = q_job.word[10];
            else if (l48_r && idx == 9'd100) acc_nxt = {48'd0, q_job.word};
            else if (l48_r && idx == 9'd101) acc_nxt[31:16] = acc_r[31:16] | q_job.word;
            else if (l48_r && idx == 9'd102) acc_nxt[47:32] = acc_r[47:32] | q_job.word;
            else if (l48_r && idx == 9'd103) acc_nxt[63:48] = acc_r[63:48] | q_job.word;
            wl_nxt = wdec;
            if (wdec != 9'd0)
              r0_nxt = mk(K_BRD, ch, 1'b0, 3'd0, 1'b1, 16'd0, ST_OK, 64'd0);
            else begin
              pres_nxt[drv_r] = 1'b1; phase_nxt = PH_IDLE;
              r0_nxt = mk(K_DONE, ch, 1'b0, 3'd0, 1'b0, 16'd0, ST_OK, acc_nxt);
            end
          end
        end
        (q_job.op == OP_HWW && phase_r == PH_WDATA): begin
          busy_nxt = 1'b1; sc_nxt = SC_TWO; len_nxt = 4'd1;
          r0_nxt = mk(K_BWR, ch, 1'b0, 3'd0, 1'b0, q_job.word, ST_OK, 64'd0);
          wl_nxt = wdec;
          if (wdec != 9'd0) begin
            sc_nxt = SC_ONE; len_nxt = 4'd0;
            r1_nxt = mk(K_NEED, ch, 1'b0, 3'd0, 1'b0, 16'd0, ST_OK, 64'd0);
            r0_nxt.kind = K_BWR;
            // emit word write then request
            sc_nxt = SC_TWO; len_nxt = 4'd1;
          end else begin
            sec_nxt = sdec; pc_nxt = 20'd1;
            if (sdec != 9'd0) begin
              phase_nxt = PH_XFER;
              r1_nxt = mk(K_BRD, ch, 1'b0, 3'd7, 1'b1, 16'd0, ST_OK, 64'd0);
            end else begin
              // flush: word, E7 write, status read
              phase_nxt = PH_FLUSH; len_nxt = 4'd2;
              r1_nxt = mk(K_BWR, ch, 1'b0, 3'd7, 1'b0, 16'h00E7, ST_OK, 64'd0);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r0_r <= r0_nxt; r1_r <= r1_nxt; lba_r <= lba_nxt; cnt_r <= cnt_nxt; opw_r <= opw_nxt;
    if (!rst_n) begin
      phase_r <= PH_IDLE; drv_r <= 2'd0; isw_r <= 1'b0; sec_r <= 9'd0; wl_r <= 9'd0;
      pc_r <= 20'd0; pres_r <= 4'd0; l48_r <= 1'b0; acc_r <= 64'd0; rbs_r <= 8'd0;
      busy_r <= 1'b0; sc_r <= SC_ONE; step_r <= 4'd0; len_r <= 4'd0;
    end else begin
      phase_r <= phase_nxt; drv_r <= drv_nxt; isw_r <= isw_nxt; sec_r <= sec_nxt;
      wl_r <= wl_nxt; pc_r <= pc_nxt; pres_r <= pres_nxt; l48_r <= l48_nxt;
      acc_r <= acc_nxt; rbs_r <= rbs_nxt;
      busy_r <= busy_nxt; sc_r <= sc_nxt; step_r <= step_nxt; len_r <= len_nxt;
    end
  end
endmodule

FILE: design/ata_pio_host_sequencer.sv
// ----------------------------------------------------------------------------
// ata_pio_host_sequencer
// Top level: input queue feeding the task-file sequencer.
// ----------------------------------------------------------------------------
// the first result of an item, if any, is valid in the cycle after it leaves the input queue
// throughput: one result per cycle while out_tready is high; while one item's results
// leave the sequencer, the two-entry queue absorbs up to two further items
// reset: synchronous, active low; all drives absent, poll limit 100000
module ata_pio_host_sequencer #(
  parameter int unsigned WORDS_PER_SECTOR = aph_pkg::WordsPerSectorDef,
  parameter int unsigned NUM_DRIVES       = aph_pkg::NumDrivesDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [19:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,  // opcode, drive, lba, sector_count, word (pad 7)
  input  logic         out_tready,
  output logic         out_tvalid,
  output logic [2:0]   out_tuser, // kind
  output logic         out_tlast,
  output logic [95:0]  out_tdata  // channel, use_ctrl_port, reg_offset, wants_reply,
                                  // data, status, sector_total (pad 7)
);
  import aph_pkg::*;

  logic [19:0] lim_r;
  aph_job_t    ij, qj;
  logic        qv, qr;
  aph_res_t    rs;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) lim_r <= PollLimitReset;
    else if (cfg_valid) lim_r <= cfg_data;
  end

  // job fields run op, drive, lba, cnt, word from the top bit down
  assign ij = {in_tdata[2:0], in_tdata[4:3], in_tdata[32:5], in_tdata[40:33],
               in_tdata[56:41]};

  aph_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready), .in_job(ij),
    .q_valid(qv), .q_ready(qr), .q_job(qj)
  );

  aph_back #(.WORDS_PER_SECTOR(WORDS_PER_SECTOR), .NUM_DRIVES(NUM_DRIVES)) u_back (
    .clk(clk), .rst_n(rst_n), .poll_limit(lim_r), .q_valid(qv), .q_ready(qr), .q_job(qj),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(rs)
  );

  assign out_tuser = rs.kind;
  assign out_tlast = rs.last;
  assign out_tdata = {7'd0, rs.sector_total, rs.status, rs.data, rs.wants_reply,
                      rs.reg_offset, rs.use_ctrl_port, rs.channel};
endmodule

FILE: design/aph_checker.sv
// ----------------------------------------------------------------------------
// aph_checker
// Port-level checks for the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module aph_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [2:0]  out_tuser,
  input logic        out_tlast,
  input logic [95:0] out_tdata
);
  import aph_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == K_DONE |-> out_tlast)
    else $error("done not last");
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != K_DONE |-> out_tdata[88:25] == 64'd0)
    else $error("total outside done");
endmodule

bind ata_pio_host_sequencer aph_checker u_aph_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tuser(out_tuser), .out_tlast(out_tlast), .out_tdata(out_tdata)
);
